// ===== src/mtis_pkg.sv =====
// ----------------------------------------------------------------------------
// mtis_pkg
// Shared widths, field positions and codes for the table interval search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtis_pkg;

  // field widths
  localparam int KEY_W         = 32;
  localparam int IDX_W         = 10;
  localparam int SIZE_W        = 11;
  localparam int DEFAULT_DEPTH = 1024;

  // stream packing
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_KEY_LSB   = IN_IDX_LSB + IDX_W;
  localparam int IN_TDATA_W   = ((IN_KEY_LSB + KEY_W + 7) / 8) * 8;
  localparam int OUT_IDX_LSB  = 0;
  localparam int OUT_DESC_BIT = OUT_IDX_LSB + IDX_W;
  localparam int OUT_TDATA_W  = ((OUT_DESC_BIT + 1 + 7) / 8) * 8;

  // action codes carried in in_tuser
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

endpackage

`default_nettype wire

// ===== src/mtis_table.sv =====
// ----------------------------------------------------------------------------
// mtis_table
// Key table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtis_table #(
  parameter int DEPTH = mtis_pkg::DEFAULT_DEPTH,
  parameter int AW    = 10
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [mtis_pkg::KEY_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [mtis_pkg::KEY_W-1:0] rd_data
);
  import mtis_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data in the cycle after the address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/monotonic_table_interval_search.sv =====
// ----------------------------------------------------------------------------
// monotonic_table_interval_search
// Loads a table of signed Q16.16 keys and finds the interval bracketing a key.
// ----------------------------------------------------------------------------
// A write transaction (tuser = 0) stores one key. A search transaction
// (tuser = 1) infers the table order from entries 0 and 1, then runs a
// binary search with one signed comparator and one table read port: setup
// reads entries 0 and 1, then each probe reads the midpoint entry and, where
// the midpoint can bracket the key, the entry after it, with at most
// floor(log2(n)) + 1 probes for n entries in use; a search with no match
// ends when the range runs empty. With fewer than two entries in use a
// search goes straight to the result with no table read.
// in_tready is low while a search runs; a finished result may wait in the
// output register while the next transaction is taken, and a second finished
// result holds the sequencer until that register drains.
`timescale 1ns / 1ps
`default_nettype none

module monotonic_table_interval_search #(
  parameter int TABLE_DEPTH = mtis_pkg::DEFAULT_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration: entries_in_use
  input  wire logic                            cfg_we,
  input  wire logic [mtis_pkg::SIZE_W-1:0]     cfg_wdata,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tdata: entry_index[9:0], key_value[41:10], zero pad
  input  wire logic [mtis_pkg::IN_TDATA_W-1:0] in_tdata,
  // tuser: action[0]
  input  wire logic [0:0]                      in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // tdata: interval_index[9:0], descending[10], zero pad
  output logic [mtis_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // tuser: found[0]
  output logic [0:0]                           out_tuser
);
  import mtis_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = SIZE_W + 1;
  localparam logic signed [CW-1:0] POS_ONE  = CW'(1);
  localparam logic signed [CW-1:0] POS_ZERO = '0;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_E0   = 8'b0000_0010,
    S_E1   = 8'b0000_0100,
    S_DIR  = 8'b0000_1000,
    S_LOOP = 8'b0001_0000,
    S_CHK1 = 8'b0010_0000,
    S_CHK2 = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]       cfg_size_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic                    out_desc_r;

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] e0_r;
  logic signed [CW-1:0]    left_r, right_r, mid_r, last_r;
  logic                    desc_r, mv_left_r, found_r;
  logic [IDX_W-1:0]        res_idx_r;

  // input field decode
  logic                    in_action;
  logic [IDX_W-1:0]        in_idx;
  logic signed [KEY_W-1:0] in_key;
  logic                    in_accept;

  assign in_action = in_tuser[0];
  assign in_idx    = in_tdata[IN_IDX_LSB +: IDX_W];
  assign in_key    = signed'(in_tdata[IN_KEY_LSB +: KEY_W]);
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // saturate count to the table depth
  logic [SIZE_W-1:0] size_c;
  always_comb begin
    if (32'(cfg_size_r) > TABLE_DEPTH) begin
      size_c = SIZE_W'(TABLE_DEPTH);
    end else begin
      size_c = cfg_size_r;
    end
  end

  // table storage
  logic             wr_en;
  logic             rd_en;
  logic [CW-1:0]    rd_pos;
  logic [KEY_W-1:0] rd_data;

  assign wr_en = in_accept && (in_action == ACT_WRITE) && (32'(in_idx) < TABLE_DEPTH);

  mtis_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_idx)),
    .wr_data (in_key),
    .rd_en   (rd_en),
    .rd_addr (AW'(rd_pos)),
    .rd_data (rd_data)
  );

  // shared signed comparator
  logic signed [KEY_W-1:0] cmp_a, cmp_b;
  logic                    cmp_lt, cmp_eq;

  always_comb begin
    if (state_r == S_DIR) begin
      cmp_a = e0_r;
      cmp_b = signed'(rd_data);
    end else begin
      cmp_a = signed'(rd_data);
      cmp_b = key_r;
    end
  end

  assign cmp_lt = (cmp_a < cmp_b);
  assign cmp_eq = (cmp_a == cmp_b);

  // probe decisions in the inferred direction
  logic cond_lo, cond_hi, mv_left_c, mid_last;
  assign cond_lo   = desc_r ? !cmp_lt : (cmp_lt || cmp_eq);
  assign cond_hi   = desc_r ? cmp_lt : !(cmp_lt || cmp_eq);
  assign mv_left_c = desc_r ? !(cmp_lt || cmp_eq) : cmp_lt;
  assign mid_last  = (mid_r == last_r);

  // midpoint of the live range
  logic signed [CW-1:0] mid_c;
  logic                 loop_ok;
  assign mid_c   = left_r + ((right_r - left_r) >>> 1);
  assign loop_ok = (left_r <= right_r);

  // read address selection
  always_comb begin
    rd_en  = 1'b0;
    rd_pos = '0;
    case (state_r)
      S_E0: begin
        rd_en  = 1'b1;
        rd_pos = '0;
      end
      S_E1: begin
        rd_en  = 1'b1;
        rd_pos = CW'(1);
      end
      S_LOOP: begin
        rd_en  = loop_ok;
        rd_pos = $unsigned(mid_c);
      end
      S_CHK1: begin
        rd_en  = cond_lo && !mid_last;
        rd_pos = $unsigned(mid_r + POS_ONE);
      end
      default: begin
        rd_en  = 1'b0;
        rd_pos = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept && (in_action == ACT_SEARCH)) begin
          state_nxt = (size_c < SIZE_W'(2)) ? S_OUT : S_E0;
        end
      end
      S_E0:   state_nxt = S_E1;
      S_E1:   state_nxt = S_DIR;
      S_DIR:  state_nxt = S_LOOP;
      S_LOOP: state_nxt = loop_ok ? S_CHK1 : S_OUT;
      S_CHK1: begin
        if (cond_lo && mid_last) begin
          state_nxt = S_OUT;
        end else if (cond_lo) begin
          state_nxt = S_CHK2;
        end else begin
          state_nxt = S_LOOP;
        end
      end
      S_CHK2: state_nxt = cond_hi ? S_OUT : S_LOOP;
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((state_r == S_OUT) && (!out_valid_r || out_tready)) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cfg_size_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_size_r <= cfg_wdata;
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_accept && (in_action == ACT_SEARCH)) begin
          key_r     <= in_key;
          found_r   <= 1'b0;
          res_idx_r <= '0;
          desc_r    <= 1'b0;
          last_r    <= signed'(CW'(size_c)) - POS_ONE;
        end
      end
      S_E1: begin
        e0_r <= signed'(rd_data);
      end
      S_DIR: begin
        desc_r  <= !cmp_lt;
        left_r  <= POS_ZERO;
        right_r <= last_r;
      end
      S_LOOP: begin
        mid_r <= mid_c;
      end
      S_CHK1: begin
        mv_left_r <= mv_left_c;
        if (cond_lo && mid_last) begin
          found_r   <= 1'b1;
          res_idx_r <= IDX_W'(mid_r);
        end else if (!cond_lo) begin
          if (mv_left_c) begin
            left_r <= mid_r + POS_ONE;
          end else begin
            right_r <= mid_r - POS_ONE;
          end
        end
      end
      S_CHK2: begin
        if (cond_hi) begin
          found_r   <= 1'b1;
          res_idx_r <= IDX_W'(mid_r);
        end else if (mv_left_r) begin
          left_r <= mid_r + POS_ONE;
        end else begin
          right_r <= mid_r - POS_ONE;
        end
      end
      default: begin
      end
    endcase
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && (!out_valid_r || out_tready)) begin
      out_found_r <= found_r;
      out_idx_r   <= res_idx_r;
      out_desc_r  <= desc_r;
    end
  end

  // result stream packing
  always_comb begin
    out_tdata                             = '0;
    out_tdata[OUT_IDX_LSB +: IDX_W]       = out_idx_r;
    out_tdata[OUT_DESC_BIT]               = out_desc_r;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_found_r;

endmodule

`default_nettype wire

// ===== src/mtis_checker.sv =====
// ----------------------------------------------------------------------------
// mtis_checker
// Port-level checks for the table interval search, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtis_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [0:0]                       in_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [mtis_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [0:0]                       out_tuser
);
  import mtis_pkg::*;

  logic in_write_acc, in_search_acc;
  assign in_write_acc  = in_tvalid && in_tready && (in_tuser[0] == ACT_WRITE);
  assign in_search_acc = in_tvalid && in_tready && (in_tuser[0] == ACT_SEARCH);

  // a write transaction never starts a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_write_acc && !out_tvalid) |=> !out_tvalid)
    else $error("result appeared after a write transaction");

  // a search keeps the input side busy on the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_search_acc |=> !in_tready)
    else $error("input ready right after a search transaction");

  // a new result only follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result rose without a search in progress");

  // not found reports index zero
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[OUT_IDX_LSB +: IDX_W] == '0))
    else $error("not-found result with nonzero interval index");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind monotonic_table_interval_search mtis_checker u_mtis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/interval_search_checker.sv =====
// ----------------------------------------------------------------------------
// interval_search_checker
// Watches the configuration port and both streams of the interval search,
// keeps its own copy of the key table and entry count, works out the
// bracketing interval for every accepted search and compares each result
// transaction, field by field, with the oldest outstanding lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_search_checker
  import mtis_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [SIZE_W-1:0]      cfg_wdata,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  // tdata: entry_index[9:0], key_value[41:10], zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: action[0]
  input  wire logic [0:0]             in_tuser,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  // tdata: interval_index[9:0], descending[10], zero pad
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  // tuser: found[0]
  input  wire logic [0:0]             out_tuser,
  output int unsigned                 pending,
  output int unsigned                 mismatch_count
);

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
    logic             desc;
  } interval_t;

  bit signed [KEY_W-1:0] key_bounds [TABLE_DEPTH];
  logic [SIZE_W-1:0]     span;
  interval_t             expected_intervals [$];
  int unsigned           results_seen;

  // binary search over the entries in use, order taken from entries 0 and 1
  function automatic interval_t locate_interval(input bit signed [KEY_W-1:0] probe);
    interval_t res;
    int        n, lo, hi, mid;
    bit        down, hit, done;
    res = '0;
    n   = (span > TABLE_DEPTH) ? TABLE_DEPTH : int'(span);
    if (n < 2) return res;
    down = !(key_bounds[0] < key_bounds[1]);
    lo   = 0;
    hi   = n - 1;
    done = 1'b0;
    while (lo <= hi && !done) begin
      mid = lo + (hi - lo) / 2;
      if (!down)
        hit = key_bounds[mid] <= probe && (mid == n - 1 || key_bounds[mid + 1] > probe);
      else
        hit = key_bounds[mid] >= probe && (mid == n - 1 || key_bounds[mid + 1] < probe);
      if (hit) begin
        res.found = 1'b1;
        res.index = IDX_W'(mid);
        done      = 1'b1;
      end else if (down ? key_bounds[mid] > probe : key_bounds[mid] < probe) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    res.desc = down;
    return res;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  // transaction monitor: results first, then config, then new input
  always @(posedge clk) begin
    interval_t             want;
    interval_t             got;
    bit signed [KEY_W-1:0] key;
    int                    idx;
    if (!rst_n) begin
      span <= '0;
      expected_intervals.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.found = out_tuser[0];
        got.index = out_tdata[OUT_IDX_LSB +: IDX_W];
        got.desc  = out_tdata[OUT_DESC_BIT];
        if (expected_intervals.size() == 0) begin
          report_mismatch($sformatf("no search outstanding, got found=%0b index=%0d desc=%0b",
                                    got.found, got.index, got.desc));
        end else begin
          want = expected_intervals.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found got %0b expected %0b", got.found, want.found));
          if (got.index !== want.index)
            report_mismatch($sformatf("interval_index got %0d expected %0d",
                                      got.index, want.index));
          if (got.desc !== want.desc)
            report_mismatch($sformatf("descending got %0b expected %0b", got.desc, want.desc));
        end
        results_seen++;
      end

      if (cfg_we) span <= cfg_wdata;

      if (in_tvalid && in_tready) begin
        key = in_tdata[IN_KEY_LSB +: KEY_W];
        idx = int'(in_tdata[IN_IDX_LSB +: IDX_W]);
        if (in_tuser[0] == ACT_SEARCH)
          expected_intervals.push_back(locate_interval(key));
        else if (idx < TABLE_DEPTH)
          key_bounds[idx] = key;
      end

      pending <= expected_intervals.size();
    end
  end

endmodule

// ===== tb/tb_monotonic_table_interval_search.sv =====
// ----------------------------------------------------------------------------
// tb_monotonic_table_interval_search
// Drives table loads and key searches into the interval search block: a short
// directed pass over empty, tiny, flat and out-of-range cases, then phases
// of random table shapes and sizes with random sender gaps and receiver
// stalls. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_monotonic_table_interval_search;
  import mtis_pkg::*;

  localparam int          TABLE_DEPTH = DEFAULT_DEPTH;
  localparam int          ITEM_TARGET = 1550;
  localparam int          SIZE_MAX    = (1 << SIZE_W) - 1;
  localparam int          SETTLE_GAP  = 8;
  localparam int          DRAIN_GAP   = 60;
  localparam int          CYCLE_LIMIT = 500000;
  localparam logic [31:0] KEY_MIN     = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX     = 32'h7FFF_FFFF;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [SIZE_W-1:0]      cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // tdata: entry_index[9:0], key_value[41:10], zero pad
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // tuser: action[0]
  logic [0:0]             in_tuser   = ACT_WRITE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // tdata: interval_index[9:0], descending[10], zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  // tuser: found[0]
  logic [0:0]             out_tuser;

  int unsigned            pending;
  int unsigned            mismatch_count;
  int unsigned            cycle_count = 0;
  int                     items_sent  = 0;
  int                     filled      = 0;
  bit                     calm        = 1'b0;
  logic [KEY_W-1:0]       table_vals [TABLE_DEPTH];

  monotonic_table_interval_search u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  interval_search_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .pending        (pending),
    .mismatch_count (mismatch_count)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result receiver with random stalls
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // send one transaction after a random gap, return at its handshake
  task automatic push_item(input logic act, input int idx, input logic [KEY_W-1:0] key);
    logic [IN_TDATA_W-1:0] word;
    int                    gap;
    word                      = '0;
    word[IN_IDX_LSB +: IDX_W] = idx[IDX_W-1:0];
    word[IN_KEY_LSB +: KEY_W] = key;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    if (act == ACT_WRITE) table_vals[idx] = key;
    items_sent++;
  endtask

  // hold off until every lookup has returned and a trailing write has landed
  task automatic settle;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic set_entries(input int count);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= count[SIZE_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // fill entries 0..m-1: ascending, descending, with repeats, flat or noise
  task automatic load_table(input int m);
    longint unsigned  offs [TABLE_DEPTH];
    longint unsigned  step_cap;
    longint unsigned  base;
    int               shape;
    bit               repeats;
    logic [KEY_W-1:0] v;
    shape    = $urandom_range(0, 9);
    repeats  = (shape == 6 || shape == 7);
    step_cap = 64'hFFFF_FFFF / m;
    if ($urandom_range(0, 1) == 1 && step_cap > 1000) step_cap = $urandom_range(1, 1000);
    offs[0] = 0;
    for (int i = 1; i < m; i++)
      offs[i] = offs[i-1] + ((repeats && $urandom_range(0, 3) == 0) ?
                             0 : $urandom_range(1, 32'(step_cap)));
    base = $urandom_range(0, 32'(64'hFFFF_FFFF - offs[m-1]));
    for (int i = 0; i < m; i++) begin
      case (shape)
        0, 1, 2, 6: v = 32'(base + offs[i]) ^ KEY_MIN;
        3, 4, 5, 7: v = 32'(base + offs[m-1-i]) ^ KEY_MIN;
        8:          v = 32'(base) ^ KEY_MIN;
        default:    v = $urandom;
      endcase
      push_item(ACT_WRITE, i, v);
    end
  endtask

  // search keys: table hits, neighbors of entries, range ends, anything
  function automatic logic [KEY_W-1:0] pick_key(input int m);
    int j;
    int sel;
    if (m == 0) return $urandom;
    j   = $urandom_range(0, m - 1);
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: return table_vals[j];
      3:       return table_vals[j] + 1;
      4:       return table_vals[j] - 1;
      5:       return KEY_MIN;
      6:       return KEY_MAX;
      default: return $urandom;
    endcase
  endfunction

  task automatic directed_cases;
    // too few entries: empty and single-entry tables
    set_entries(0);
    push_item(ACT_SEARCH, 0, 32'h0000_0000);
    set_entries(1);
    push_item(ACT_SEARCH, TABLE_DEPTH - 1, KEY_MAX);
    // two entries spanning the whole key range, top index written too
    push_item(ACT_WRITE, 0, KEY_MIN);
    push_item(ACT_WRITE, 1, KEY_MAX);
    push_item(ACT_WRITE, TABLE_DEPTH - 1, 32'h0001_8000);
    set_entries(2);
    push_item(ACT_SEARCH, 0, KEY_MIN);
    push_item(ACT_SEARCH, 0, KEY_MAX);
    push_item(ACT_SEARCH, 0, 32'h0000_0000);
    // descending pair
    push_item(ACT_WRITE, 0, KEY_MAX);
    push_item(ACT_WRITE, 1, KEY_MIN);
    push_item(ACT_SEARCH, 0, KEY_MAX);
    push_item(ACT_SEARCH, 0, KEY_MIN);
    push_item(ACT_SEARCH, 0, 32'hFFFF_0000);
    // equal pair reads as descending, a key equal to both has no interval
    push_item(ACT_WRITE, 1, KEY_MAX);
    push_item(ACT_SEARCH, 0, KEY_MAX);
    push_item(ACT_SEARCH, 0, 32'h0000_0000);
    // ascending -5.0, 5.0, 10.0: below first, last entry, middle, beyond
    push_item(ACT_WRITE, 0, 32'hFFFB_0000);
    push_item(ACT_WRITE, 1, 32'h0005_0000);
    push_item(ACT_WRITE, 2, 32'h000A_0000);
    set_entries(3);
    push_item(ACT_SEARCH, 0, 32'hFFFA_0000);
    push_item(ACT_SEARCH, 0, 32'h000A_0000);
    push_item(ACT_SEARCH, 0, 32'h0007_0000);
    push_item(ACT_SEARCH, 0, KEY_MAX);
    filled = 3;
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int n, m, pick, probes, phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    directed_cases();

    // random phases: new count, maybe a new table, then a burst of searches
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      if (phase == 2)
        n = TABLE_DEPTH;
      else if (phase == 3)
        n = SIZE_MAX;
      else if (pick == 0)
        n = $urandom_range(0, 1);
      else if (pick == 1)
        n = $urandom_range(100, 300);
      else if (pick == 2 && filled >= TABLE_DEPTH)
        n = $urandom_range(TABLE_DEPTH + 1, SIZE_MAX);
      else
        n = $urandom_range(2, 40);
      m = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
      set_entries(n);
      if (m > 1 && (m > filled || (m <= 300 && $urandom_range(0, 3) != 0))) begin
        load_table(m);
        if (m > filled) filled = m;
      end
      probes = (m == TABLE_DEPTH) ? 40 : $urandom_range(8, 30);
      // mostly searches, with the odd overwrite of an entry already loaded
      repeat (probes) begin
        if ($urandom_range(0, 9) == 0)
          push_item(ACT_WRITE, $urandom_range(0, filled - 1), $urandom);
        else
          push_item(ACT_SEARCH, $urandom_range(0, TABLE_DEPTH - 1), pick_key(m));
      end
      phase++;
    end

    settle();
    repeat (DRAIN_GAP) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mtis_pkg.sv
src/mtis_table.sv
src/monotonic_table_interval_search.sv
src/mtis_checker.sv
tb/interval_search_checker.sv
tb/tb_monotonic_table_interval_search.sv
